### rtl/core/arem_pkg.sv
package arem_pkg;

    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 16;
    localparam int SIZE_W     = 32;
    localparam int WIDTH_W    = 16;
    localparam int RATE_W     = 55;
    localparam int LIVE_W     = 48;
    localparam int AVG_W      = 64;
    localparam int NUM_EMA    = 3;
    localparam int IN_DATA_W  = COUNT_W + SIZE_W;
    localparam int OUT_DATA_W = 3 * (RATE_W + 1) + 2 * LIVE_W;

    // fast, medium and slow decay
    localparam int unsigned EMA_SHIFT [NUM_EMA] = '{1, 6, 9};

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0]  size_bytes;
        logic [COUNT_W-1:0] object_count;
    } in_data_t;

    typedef struct packed {
        logic [LIVE_W-1:0] live_blocks;
        logic [LIVE_W-1:0] live_bytes;
        logic              slow_growing;
        logic [RATE_W-1:0] slow_rate;
        logic              medium_growing;
        logic [RATE_W-1:0] medium_rate;
        logic              fast_growing;
        logic [RATE_W-1:0] fast_rate;
    } out_data_t;

endpackage

### rtl/core/arem_ema_bank.sv
module arem_ema_bank #(
    parameter int DELTA_BITS       = 48,
    parameter int RATE_SCALE_SHIFT = 9
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic [DELTA_BITS-1:0]                           delta,
    output logic [arem_pkg::NUM_EMA-1:0][arem_pkg::AVG_W-1:0] avg
);
    import arem_pkg::*;

    logic [NUM_EMA-1:0][AVG_W-1:0] avg_reg;
    logic [NUM_EMA-1:0][AVG_W-1:0] avg_next;
    logic [AVG_W-1:0]              scaled;

    assign scaled = AVG_W'(delta) << RATE_SCALE_SHIFT;

    always_comb
    begin
        avg_next = avg_reg;
        if (en)
        begin
            for (int i = 0; i < NUM_EMA; i++)
            begin
                avg_next[i] = avg_reg[i] + (scaled >> EMA_SHIFT[i])
                              - (avg_reg[i] >> EMA_SHIFT[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

### rtl/core/alloc_rate_ema_monitor_unit.sv
// allocation rate monitor with fast, medium and slow moving averages
// s_tdata carries allocate / free sizes, s_tuser the event kind (allocate,
// free, period tick); every accepted event yields exactly one result on m_*
// holding the three net rates with their growth flags, live bytes and blocks.
// cfg_data sets the object width (0 selects variable-size byte counting);
// it may only be written while no event is in flight.
// the result reaches m_tdata through the input, post and output registers.
// throughput: one event per cycle when not stalled; the tick path reads a pending
// byte delta kept up to date on each allocate / free, so no multiply sits on it.
// after a configuration write s_tready stays low in RC_MUL and RC_SUM while
// width times pending objects (one 16 x counter multiply) is rebuilt.
// reset clears all counters, the averages and the object width.
// when m_tready is low the result register holds, the pipeline behind it
// stalls, and s_tready drops once the input register is full.
module alloc_rate_ema_monitor_unit #(
    parameter int COUNTER_BITS     = 48,
    parameter int RATE_SCALE_SHIFT = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // object_count, size_bytes
    input  logic [arem_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic [arem_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fast_rate, fast_growing, medium_rate, medium_growing, slow_rate,
    // slow_growing, live_bytes, live_blocks
    output logic [arem_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [arem_pkg::WIDTH_W-1:0]      cfg_data
);
    import arem_pkg::*;

    localparam logic [1:0] RC_IDLE = 2'd0;
    localparam logic [1:0] RC_MUL  = 2'd1;
    localparam logic [1:0] RC_SUM  = 2'd2;

    logic [1:0]              rc_state_reg, rc_state_next;
    logic [WIDTH_W-1:0]      width_reg;

    logic                    in_valid_reg;
    in_data_t                in_data_reg;
    logic [KIND_W-1:0]       in_kind_reg;
    logic                    post_valid_reg;
    logic                    out_valid_reg;
    out_data_t               out_data_reg, out_data_next;

    logic                    out_move, post_move, rc_idle, proc, s_accept, cfg_accept;
    logic                    tick_en;

    // pending objects, width x pending objects, byte delta since last tick,
    // and the byte delta the next tick will feed
    logic [COUNTER_BITS-1:0] pend_a_reg, pend_a_next, pend_f_reg, pend_f_next;
    logic [COUNTER_BITS-1:0] wp_a_reg, wp_a_next, wp_f_reg, wp_f_next;
    logic [COUNTER_BITS-1:0] diff_a_reg, diff_a_next, diff_f_reg, diff_f_next;
    logic [COUNTER_BITS-1:0] td_a_reg, td_a_next, td_f_reg, td_f_next;
    logic [COUNTER_BITS-1:0] live_bytes_reg, live_bytes_next;
    logic [COUNTER_BITS-1:0] live_blocks_reg, live_blocks_next;

    logic                    var_mode;
    logic [SIZE_W-1:0]       unit_prod, add_bytes, var_size;
    logic [WIDTH_W+COUNTER_BITS-1:0] prod_a, prod_f;

    logic [NUM_EMA-1:0][AVG_W-1:0] alloc_avg, free_avg;
    logic [NUM_EMA-1:0][AVG_W-1:0] rate_diff;
    logic [NUM_EMA-1:0]            rate_gt;
    logic [AVG_W-1:0]              live_bytes_w, live_blocks_w;

    // handshakes
    assign rc_idle    = (rc_state_reg == RC_IDLE);
    assign out_move   = !out_valid_reg || m_tready;
    assign post_move  = !post_valid_reg || out_move;
    assign proc       = in_valid_reg && post_move && rc_idle;
    assign s_tready   = rc_idle && (!in_valid_reg || post_move);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign tick_en    = proc && (in_kind_reg == KIND_TICK);

    always_comb
    begin
        case (rc_state_reg)
            RC_MUL:  rc_state_next = RC_SUM;
            RC_SUM:  rc_state_next = RC_IDLE;
            default: rc_state_next = RC_IDLE;
        endcase
        if (cfg_accept)
        begin
            rc_state_next = RC_MUL;
        end
    end

    // counter update
    assign var_mode  = (width_reg == '0);
    assign unit_prod = width_reg * in_data_reg.object_count;
    assign var_size  = var_mode ? in_data_reg.size_bytes : '0;
    assign add_bytes = var_mode ? in_data_reg.size_bytes : unit_prod;
    assign prod_a    = width_reg * pend_a_reg;
    assign prod_f    = width_reg * pend_f_reg;

    always_comb
    begin
        pend_a_next      = pend_a_reg;
        pend_f_next      = pend_f_reg;
        wp_a_next        = wp_a_reg;
        wp_f_next        = wp_f_reg;
        diff_a_next      = diff_a_reg;
        diff_f_next      = diff_f_reg;
        td_a_next        = td_a_reg;
        td_f_next        = td_f_reg;
        live_bytes_next  = live_bytes_reg;
        live_blocks_next = live_blocks_reg;
        case (rc_state_reg)
            RC_MUL:
            begin
                wp_a_next = prod_a[COUNTER_BITS-1:0];
                wp_f_next = prod_f[COUNTER_BITS-1:0];
            end
            RC_SUM:
            begin
                td_a_next = diff_a_reg + wp_a_reg;
                td_f_next = diff_f_reg + wp_f_reg;
            end
            RC_IDLE:
            begin
                if (proc)
                begin
                    case (in_kind_reg)
                        KIND_ALLOC:
                        begin
                            pend_a_next      = pend_a_reg
                                               + COUNTER_BITS'(in_data_reg.object_count);
                            wp_a_next        = wp_a_reg + COUNTER_BITS'(unit_prod);
                            diff_a_next      = diff_a_reg + COUNTER_BITS'(var_size);
                            td_a_next        = td_a_reg + COUNTER_BITS'(add_bytes);
                            live_bytes_next  = live_bytes_reg + COUNTER_BITS'(var_size);
                            live_blocks_next = live_blocks_reg
                                               + COUNTER_BITS'(in_data_reg.object_count);
                        end
                        KIND_FREE:
                        begin
                            pend_f_next      = pend_f_reg
                                               + COUNTER_BITS'(in_data_reg.object_count);
                            wp_f_next        = wp_f_reg + COUNTER_BITS'(unit_prod);
                            diff_f_next      = diff_f_reg + COUNTER_BITS'(var_size);
                            td_f_next        = td_f_reg + COUNTER_BITS'(add_bytes);
                            live_bytes_next  = live_bytes_reg - COUNTER_BITS'(var_size);
                            live_blocks_next = live_blocks_reg
                                               - COUNTER_BITS'(in_data_reg.object_count);
                        end
                        KIND_TICK:
                        begin
                            // object snapshots only move in constant-width mode
                            if (!var_mode)
                            begin
                                pend_a_next = '0;
                                pend_f_next = '0;
                            end
                            wp_a_next       = '0;
                            wp_f_next       = '0;
                            diff_a_next     = '0;
                            diff_f_next     = '0;
                            td_a_next       = '0;
                            td_f_next       = '0;
                            live_bytes_next = live_bytes_reg + wp_a_reg - wp_f_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    arem_ema_bank #(
        .DELTA_BITS       (COUNTER_BITS),
        .RATE_SCALE_SHIFT (RATE_SCALE_SHIFT)
    ) u_alloc_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (tick_en),
        .delta (td_a_reg),
        .avg   (alloc_avg)
    );

    arem_ema_bank #(
        .DELTA_BITS       (COUNTER_BITS),
        .RATE_SCALE_SHIFT (RATE_SCALE_SHIFT)
    ) u_free_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (tick_en),
        .delta (td_f_reg),
        .avg   (free_avg)
    );

    // result built from the state left by the item in the post stage
    always_comb
    begin
        for (int i = 0; i < NUM_EMA; i++)
        begin
            rate_gt[i]   = alloc_avg[i] > free_avg[i];
            rate_diff[i] = (rate_gt[i] ? (alloc_avg[i] - free_avg[i])
                                       : (free_avg[i] - alloc_avg[i])) >> RATE_SCALE_SHIFT;
        end
        live_bytes_w                 = AVG_W'(live_bytes_reg);
        live_blocks_w                = AVG_W'(live_blocks_reg);
        out_data_next.fast_rate      = rate_diff[0][RATE_W-1:0];
        out_data_next.fast_growing   = rate_gt[0];
        out_data_next.medium_rate    = rate_diff[1][RATE_W-1:0];
        out_data_next.medium_growing = rate_gt[1];
        out_data_next.slow_rate      = rate_diff[2][RATE_W-1:0];
        out_data_next.slow_growing   = rate_gt[2];
        out_data_next.live_bytes     = live_bytes_w[LIVE_W-1:0];
        out_data_next.live_blocks    = live_blocks_w[LIVE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_state_reg    <= RC_IDLE;
            width_reg       <= '0;
            in_valid_reg    <= 1'b0;
            post_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            pend_a_reg      <= '0;
            pend_f_reg      <= '0;
            wp_a_reg        <= '0;
            wp_f_reg        <= '0;
            diff_a_reg      <= '0;
            diff_f_reg      <= '0;
            td_a_reg        <= '0;
            td_f_reg        <= '0;
            live_bytes_reg  <= '0;
            live_blocks_reg <= '0;
        end
        else
        begin
            rc_state_reg    <= rc_state_next;
            if (cfg_accept)
            begin
                width_reg <= cfg_data;
            end
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (post_move)
            begin
                post_valid_reg <= proc;
            end
            if (out_move)
            begin
                out_valid_reg <= post_valid_reg;
            end
            pend_a_reg      <= pend_a_next;
            pend_f_reg      <= pend_f_next;
            wp_a_reg        <= wp_a_next;
            wp_f_reg        <= wp_f_next;
            diff_a_reg      <= diff_a_next;
            diff_f_reg      <= diff_f_next;
            td_a_reg        <= td_a_next;
            td_f_reg        <= td_f_next;
            live_bytes_reg  <= live_bytes_next;
            live_blocks_reg <= live_blocks_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
            in_kind_reg <= s_tuser;
        end
        if (out_move && post_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### tb/tb_alloc_rate_ema_monitor_unit.sv
`timescale 1ns / 100ps

module tb_alloc_rate_ema_monitor_unit;

    import arem_pkg::*;

    localparam int CTR_W       = 48;
    localparam int RATE_SHIFT  = 9;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 6;

    // the one kind code with no meaning
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [WIDTH_W-1:0]    cfg_data;

    alloc_rate_ema_monitor_unit #(
        .COUNTER_BITS     (CTR_W),
        .RATE_SCALE_SHIFT (RATE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // monitor state as the block should hold it
    logic [WIDTH_W-1:0] obj_width;
    logic [CTR_W-1:0]   alloc_objs;
    logic [CTR_W-1:0]   free_objs;
    logic [CTR_W-1:0]   alloc_objs_snap;
    logic [CTR_W-1:0]   free_objs_snap;
    logic [CTR_W-1:0]   alloc_bytes;
    logic [CTR_W-1:0]   free_bytes;
    logic [CTR_W-1:0]   alloc_bytes_snap;
    logic [CTR_W-1:0]   free_bytes_snap;
    logic [AVG_W-1:0]   alloc_ema [NUM_EMA];
    logic [AVG_W-1:0]   free_ema [NUM_EMA];

    out_data_t expected_reports[$];

    int errors;
    int cycles;
    int events_sent;
    int ticks_sent;
    int reports_checked;
    int width_writes;
    bit src_gaps;
    bit sink_stalls;

    function automatic logic [AVG_W-1:0] ema_update(logic [AVG_W-1:0] avg,
                                                    logic [CTR_W-1:0] delta,
                                                    int unsigned sh);
        logic [AVG_W-1:0] scaled;
        scaled = AVG_W'(delta) << RATE_SHIFT;
        return avg + (scaled >> sh) - (avg >> sh);
    endfunction

    function automatic out_data_t apply_event(logic [KIND_W-1:0] kind,
                                              logic [COUNT_W-1:0] count,
                                              logic [SIZE_W-1:0] size);
        out_data_t        rep;
        logic [63:0]      prod;
        logic [AVG_W-1:0] diff;
        logic [RATE_W-1:0] rate [NUM_EMA];
        logic             grow [NUM_EMA];
        case (kind)
            KIND_ALLOC:
            begin
                alloc_objs = alloc_objs + CTR_W'(count);
                if (obj_width == 0)
                    alloc_bytes = alloc_bytes + CTR_W'(size);
            end
            KIND_FREE:
            begin
                free_objs = free_objs + CTR_W'(count);
                if (obj_width == 0)
                    free_bytes = free_bytes + CTR_W'(size);
            end
            KIND_TICK:
            begin
                if (obj_width != 0)
                begin
                    prod = 64'(obj_width) * 64'(alloc_objs - alloc_objs_snap);
                    alloc_bytes = alloc_bytes + prod[CTR_W-1:0];
                    prod = 64'(obj_width) * 64'(free_objs - free_objs_snap);
                    free_bytes = free_bytes + prod[CTR_W-1:0];
                    alloc_objs_snap = alloc_objs;
                    free_objs_snap = free_objs;
                end
                for (int i = 0; i < NUM_EMA; i++)
                begin
                    alloc_ema[i] = ema_update(alloc_ema[i], alloc_bytes - alloc_bytes_snap,
                                              EMA_SHIFT[i]);
                    free_ema[i] = ema_update(free_ema[i], free_bytes - free_bytes_snap,
                                             EMA_SHIFT[i]);
                end
                alloc_bytes_snap = alloc_bytes;
                free_bytes_snap = free_bytes;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NUM_EMA; i++)
        begin
            grow[i] = alloc_ema[i] > free_ema[i];
            diff = grow[i] ? alloc_ema[i] - free_ema[i] : free_ema[i] - alloc_ema[i];
            rate[i] = RATE_W'(diff >> RATE_SHIFT);
        end
        rep.fast_rate      = rate[0];
        rep.fast_growing   = grow[0];
        rep.medium_rate    = rate[1];
        rep.medium_growing = grow[1];
        rep.slow_rate      = rate[2];
        rep.slow_growing   = grow[2];
        rep.live_bytes     = LIVE_W'(alloc_bytes - free_bytes);
        rep.live_blocks    = LIVE_W'(alloc_objs - free_objs);
        return rep;
    endfunction

    // mostly short waits, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] count,
                              input logic [SIZE_W-1:0] size);
        int gap;
        bit rdy;
        in_data_t payload;
        gap = (src_gaps && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        payload.object_count = count;
        payload.size_bytes   = size;
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= kind;
        // ready sampled mid-cycle, so the transfer is known before the edge
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        expected_reports.push_back(apply_event(kind, count, size));
        events_sent++;
        if (kind == KIND_TICK)
            ticks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        bit rdy;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        obj_width = w;
        width_writes++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // result side: a transfer is seen at the negedge before its edge
    always @(negedge clk)
    begin
        out_data_t got;
        out_data_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = m_tdata;
            if (expected_reports.size() == 0)
            begin
                $error("result transfer with nothing outstanding: %0h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("fast_rate", want.fast_rate, got.fast_rate);
                check_field("fast_growing", want.fast_growing, got.fast_growing);
                check_field("medium_rate", want.medium_rate, got.medium_rate);
                check_field("medium_growing", want.medium_growing, got.medium_growing);
                check_field("slow_rate", want.slow_rate, got.slow_rate);
                check_field("slow_growing", want.slow_growing, got.slow_growing);
                check_field("live_bytes", want.live_bytes, got.live_bytes);
                check_field("live_blocks", want.live_blocks, got.live_blocks);
                reports_checked++;
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 99) < 25)
                    hold = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", expected_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return COUNT_W'($urandom);
            default: return COUNT_W'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4, 5: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic test_variable_width_events();
        write_width('0);
        send_event(KIND_ALLOC, '0, '0);
        send_event(KIND_ALLOC, '1, '1);
        send_event(KIND_FREE, 16'd1, 32'd100);
        send_event(KIND_TICK, '0, '0);
        // frees beyond allocations take live counts below zero
        send_event(KIND_FREE, '1, '1);
        send_event(KIND_FREE, '1, '1);
        send_event(KIND_TICK, '1, '1);
        send_event(KIND_UNUSED, '1, '1);
        send_event(KIND_TICK, '0, '0);
        send_event(KIND_TICK, '0, '0);
    endtask

    task automatic test_fixed_width_events();
        write_width('1);
        // size ignored with a fixed object width
        send_event(KIND_ALLOC, '1, '1);
        send_event(KIND_FREE, 16'd3, '1);
        send_event(KIND_TICK, '0, '0);
        send_event(KIND_UNUSED, '0, '0);
        send_event(KIND_TICK, '0, '0);
        write_width(16'd1);
        send_event(KIND_ALLOC, 16'd7, '0);
        send_event(KIND_TICK, '0, '0);
    endtask

    task automatic test_width_switch();
        // objects counted while variable-size build up unsnapshotted
        write_width('0);
        send_event(KIND_ALLOC, '1, 32'd5);
        send_event(KIND_ALLOC, '1, 32'd9);
        write_width(16'd40000);
        send_event(KIND_TICK, '0, '0);
        send_event(KIND_ALLOC, 16'd500, '0);
        write_width(16'd3);
        send_event(KIND_TICK, '0, '0);
        write_width('0);
        send_event(KIND_TICK, '0, '0);
    endtask

    task automatic test_random_traffic(input logic [WIDTH_W-1:0] w, input int n_events,
                                       input int alloc_pct, input int tick_pct,
                                       input bit gaps, input bit stalls);
        int r;
        logic [KIND_W-1:0] kind;
        write_width(w);
        src_gaps = gaps;
        sink_stalls = stalls;
        repeat (n_events)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = KIND_UNUSED;
            else if (r < 3 + tick_pct)
                kind = KIND_TICK;
            else if (r < 3 + tick_pct + alloc_pct)
                kind = KIND_ALLOC;
            else
                kind = KIND_FREE;
            send_event(kind, rand_count(), rand_size());
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        events_sent = 0;
        ticks_sent = 0;
        reports_checked = 0;
        width_writes = 0;
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        obj_width = '0;
        alloc_objs = '0;
        free_objs = '0;
        alloc_objs_snap = '0;
        free_objs_snap = '0;
        alloc_bytes = '0;
        free_bytes = '0;
        alloc_bytes_snap = '0;
        free_bytes_snap = '0;
        for (int i = 0; i < NUM_EMA; i++)
        begin
            alloc_ema[i] = '0;
            free_ema[i] = '0;
        end
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_variable_width_events();
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        test_fixed_width_events();
        test_width_switch();
        test_random_traffic('0, 225, 45, 20, 1'b0, 1'b0);
        test_random_traffic(16'd1, 225, 40, 25, 1'b1, 1'b1);
        test_random_traffic('1, 225, 30, 20, 1'b1, 1'b1);
        test_random_traffic(WIDTH_W'($urandom), 225, 50, 15, 1'b0, 1'b1);
        test_random_traffic('0, 225, 35, 30, 1'b1, 1'b0);
        test_random_traffic(WIDTH_W'($urandom), 225, 45, 20, 1'b1, 1'b1);
        drain();

        $display("%0d events sent (%0d ticks) across %0d object width writes",
                 events_sent, ticks_sent, width_writes);
        $display("%0d results compared, %0d mismatches", reports_checked, errors);
        if (errors == 0 && expected_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
